// ----- hw/rtl/mtrr_pkg.sv -----
// Shared types and constants for the memory type resolver.
// Used by the cell, the chain and the top level; depends on nothing.
package mtrr_pkg;

   localparam int TABLE_DEPTH_DEF  = 128;
   localparam int ADDRESS_BITS_DEF = 52;
   localparam int SIZE_BITS        = 6;
   localparam int TYPE_BITS        = 3;

   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_FINISH = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_SPAN = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [2:0] MT_UC = 3'd0;
   localparam logic [2:0] MT_WT = 3'd4;
   localparam logic [2:0] MT_WB = 3'd6;

   localparam logic REG_DEFAULT_TYPE = 1'b0;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_WALK,
      FSM_DRAIN
   } fsm_type;

   // lookup token status carried from cell to cell
   typedef struct packed {
      logic       valid;
      logic       done;
      logic       have;
      logic       span;
      logic [2:0] acc;
   } tok_type;

   // entry write broadcast to the cells
   typedef struct packed {
      logic       en;
      logic [3:0] kind;
   } wr_type;

endpackage

// ----- hw/rtl/mtrr_cell.sv -----
// One table entry of the resolver plus one stage of the lookup token path.
// Depends on mtrr_pkg.
module mtrr_cell #(
   parameter int ADDRESS_BITS = mtrr_pkg::ADDRESS_BITS_DEF,
   parameter int TABLE_DEPTH  = mtrr_pkg::TABLE_DEPTH_DEF,
   parameter int INDEX        = 0
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mtrr_pkg::wr_type                      wr,
   input  logic [$clog2(TABLE_DEPTH)-1:0]        wr_idx,
   input  logic [ADDRESS_BITS-1:0]               wr_base,
   input  logic [ADDRESS_BITS:0]                 wr_end,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]      count,
   input  mtrr_pkg::tok_type                     tok_in,
   input  logic [ADDRESS_BITS-1:0]               addr_in,
   input  logic [ADDRESS_BITS+1:0]               lend_in,
   output mtrr_pkg::tok_type                     tok_out,
   output logic [ADDRESS_BITS-1:0]               addr_out,
   output logic [ADDRESS_BITS+1:0]               lend_out
);
   import mtrr_pkg::*;

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [ADDRESS_BITS-1:0] base_ff;
   logic [ADDRESS_BITS:0]   end_ff;
   logic [3:0]              kind_ff;
   tok_type                 tok_ff, tok_in_n;
   logic [ADDRESS_BITS-1:0] addr_ff;
   logic [ADDRESS_BITS+1:0] lend_ff;
   logic                    live, hit;
   logic [2:0]              t;

   always_ff @(posedge clock) begin
      if (wr.en && wr_idx == IW'(INDEX)) begin
         base_ff <= wr_base;
         end_ff  <= wr_end;
         kind_ff <= wr.kind;
      end
   end

   always_comb begin
      live     = CW'(INDEX) < count;
      hit      = (addr_in >= base_ff) && ({1'b0, addr_in} < end_ff);
      t        = kind_ff[2:0];
      tok_in_n = tok_in;
      if (tok_in.valid && !tok_in.done && live && hit) begin
         if (lend_in > {1'b0, end_ff}) begin
            tok_in_n.done = 1'b1;
            tok_in_n.span = 1'b1;
            tok_in_n.acc  = MT_UC;
         end else if (kind_ff[3] || t == MT_UC) begin
            tok_in_n.done = 1'b1;
            tok_in_n.acc  = t;
         end else begin
            if (tok_in.have && ((t == MT_WT && tok_in.acc == MT_WB) ||
                                (t == MT_WB && tok_in.acc == MT_WT))) begin
               tok_in_n.acc = MT_WT;
            end else begin
               tok_in_n.acc = t;
            end
            tok_in_n.have = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_n;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      lend_ff <= lend_in;
   end

   assign tok_out  = tok_ff;
   assign addr_out = addr_ff;
   assign lend_out = lend_ff;

endmodule

// ----- hw/rtl/mtrr_chain.sv -----
// Row of resolver cells; the lookup token moves one cell per cycle.
// Depends on mtrr_pkg and mtrr_cell.
module mtrr_chain #(
   parameter int ADDRESS_BITS = mtrr_pkg::ADDRESS_BITS_DEF,
   parameter int TABLE_DEPTH  = mtrr_pkg::TABLE_DEPTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  mtrr_pkg::wr_type                      wr,
   input  logic [$clog2(TABLE_DEPTH)-1:0]        wr_idx,
   input  logic [ADDRESS_BITS-1:0]               wr_base,
   input  logic [ADDRESS_BITS:0]                 wr_end,
   input  logic [$clog2(TABLE_DEPTH+1)-1:0]      count,
   input  mtrr_pkg::tok_type                     tok_in,
   input  logic [ADDRESS_BITS-1:0]               addr_in,
   input  logic [ADDRESS_BITS+1:0]               lend_in,
   output mtrr_pkg::tok_type                     tok_out
);
   import mtrr_pkg::*;

   tok_type                 tok  [0:TABLE_DEPTH];
   logic [ADDRESS_BITS-1:0] addr [0:TABLE_DEPTH];
   logic [ADDRESS_BITS+1:0] lend [0:TABLE_DEPTH];

   assign tok[0]  = tok_in;
   assign addr[0] = addr_in;
   assign lend[0] = lend_in;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      mtrr_cell #(
         .ADDRESS_BITS(ADDRESS_BITS),
         .TABLE_DEPTH (TABLE_DEPTH),
         .INDEX       (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .wr      (wr),
         .wr_idx  (wr_idx),
         .wr_base (wr_base),
         .wr_end  (wr_end),
         .count   (count),
         .tok_in  (tok[i]),
         .addr_in (addr[i]),
         .lend_in (lend[i]),
         .tok_out (tok[i+1]),
         .addr_out(addr[i+1]),
         .lend_out(lend[i+1])
      );
   end

   assign tok_out = tok[TABLE_DEPTH];

endmodule

// ----- hw/rtl/mtrr_memory_type_resolver_unit.sv -----
// Memory type resolver top level: stream channels, APB-style CSR port,
// add/finish logic and the lookup cell chain. Depends on mtrr_pkg, mtrr_chain.
//
// Usage:
//   req_* carries one transaction per operation: add range, finish loading
//   or look up. rsp_* returns exactly one transaction for each request,
//   in order. csr_* holds the default memory type (address 0).
//   Add and finish respond directly: the response is valid the cycle
//   after the request is taken. A lookup sends a token down a row of
//   TABLE_DEPTH cells, one cell per cycle, each cell holding one stored
//   range; the cells register the token, then the walk state registers the
//   result and the drain state the response. One transaction is in flight
//   at a time; a new request is taken while the previous response still
//   waits, provided that response is taken in the same cycle.
//   Reset clears the table count, the pending range, the default type and
//   the response valid flag; stored ranges need no clearing.
//   When rsp_tready is low the response register holds its transaction and
//   req_tready stays low until it is taken.
module mtrr_memory_type_resolver_unit #(
   parameter int TABLE_DEPTH  = mtrr_pkg::TABLE_DEPTH_DEF,
   parameter int ADDRESS_BITS = mtrr_pkg::ADDRESS_BITS_DEF,
   localparam int REQ_W = ((2 * ADDRESS_BITS + 13 + 7) / 8) * 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   // operation, address, size_log2, range_fixed, range_type, lookup_size
   input  logic [REQ_W-1:0] req_tdata,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   // memory_type, status
   output logic [7:0]       rsp_tdata,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import mtrr_pkg::*;

   localparam int AW = ADDRESS_BITS;
   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic [1:0]      op;
   logic [AW-1:0]   addr;
   logic [5:0]      lg;
   logic            fixed;
   logic [2:0]      rtype;
   logic [AW:0]     len;

   assign op    = req_tdata[1:0];
   assign addr  = req_tdata[AW+1:2];
   assign lg    = req_tdata[AW+7:AW+2];
   assign fixed = req_tdata[AW+8];
   assign rtype = req_tdata[AW+11:AW+9];
   assign len   = req_tdata[2*AW+12:AW+12];

   fsm_type       state_ff, state_in;
   logic [2:0]    def_ff, def_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] pbase_ff, pbase_in;
   logic [AW:0]   pend_ff, pend_in;
   logic [3:0]    pkind_ff, pkind_in;
   logic          pvalid_ff, pvalid_in;
   logic          rvalid_ff, rvalid_in;
   logic [2:0]    rtype_ff, rtype_in;
   logic [1:0]    rstat_ff, rstat_in;
   logic [2:0]    htype_ff, htype_in;
   logic [1:0]    hstat_ff, hstat_in;

   logic          accept, out_free, full, cont, csr_wr;
   logic [5:0]    lg_sat;
   logic [AW:0]   size;
   logic [3:0]    kind;
   wr_type        wr;
   tok_type       tok_in, tok_out;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_DEFAULT_TYPE) ? {29'd0, def_ff} : 32'd0;

   assign out_free   = !rvalid_ff || rsp_tready;
   assign req_tready = (state_ff == FSM_IDLE) && out_free;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rvalid_ff;
   assign rsp_tdata  = {3'd0, rstat_ff, rtype_ff};

   always_comb begin
      lg_sat = (lg > 6'(AW)) ? 6'(AW) : lg;
      size   = (AW+1)'(1) << lg_sat;
      kind   = {fixed, rtype};
      full   = count_ff == CW'(TABLE_DEPTH);
      cont   = pvalid_ff && pkind_ff == kind && pend_ff == {1'b0, addr};

      state_in  = state_ff;
      def_in    = csr_wr && csr_paddr[2] == REG_DEFAULT_TYPE ? csr_pwdata[2:0] : def_ff;
      count_in  = count_ff;
      pbase_in  = pbase_ff;
      pend_in   = pend_ff;
      pkind_in  = pkind_ff;
      pvalid_in = pvalid_ff;
      rvalid_in = rvalid_ff && !rsp_tready;
      rtype_in  = rtype_ff;
      rstat_in  = rstat_ff;
      htype_in  = htype_ff;
      hstat_in  = hstat_ff;
      wr        = '0;
      tok_in    = '0;

      unique case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               rtype_in = MT_UC;
               rstat_in = ST_OK;
               unique case (op)
                  OP_ADD: begin
                     rvalid_in = 1'b1;
                     if (cont) begin
                        pend_in = pend_ff + size;
                     end else if (pvalid_ff && full) begin
                        rstat_in = ST_FULL;
                     end else begin
                        wr.en     = pvalid_ff;
                        wr.kind   = pkind_ff;
                        count_in  = count_ff + CW'(pvalid_ff);
                        pbase_in  = addr;
                        pend_in   = {1'b0, addr} + size;
                        pkind_in  = kind;
                        pvalid_in = 1'b1;
                     end
                  end
                  OP_FINISH: begin
                     rvalid_in = 1'b1;
                     if (pvalid_ff && full) begin
                        rstat_in = ST_FULL;
                     end else if (pvalid_ff) begin
                        wr.en     = 1'b1;
                        wr.kind   = pkind_ff;
                        count_in  = count_ff + CW'(1);
                        pvalid_in = 1'b0;
                     end
                  end
                  OP_LOOKUP: begin
                     tok_in.valid = 1'b1;
                     state_in     = FSM_WALK;
                  end
                  default: begin
                     rvalid_in = 1'b1;
                  end
               endcase
            end
         end
         FSM_WALK: begin
            if (tok_out.valid) begin
               hstat_in = tok_out.span ? ST_SPAN : ST_OK;
               htype_in = (tok_out.done || tok_out.have) ? tok_out.acc : def_ff;
               state_in = FSM_DRAIN;
            end
         end
         FSM_DRAIN: begin
            if (out_free) begin
               rvalid_in = 1'b1;
               rtype_in  = htype_ff;
               rstat_in  = hstat_ff;
               state_in  = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FSM_IDLE;
         def_ff    <= MT_UC;
         count_ff  <= '0;
         pbase_ff  <= '0;
         pend_ff   <= '0;
         pkind_ff  <= '0;
         pvalid_ff <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         def_ff    <= def_in;
         count_ff  <= count_in;
         pbase_ff  <= pbase_in;
         pend_ff   <= pend_in;
         pkind_ff  <= pkind_in;
         pvalid_ff <= pvalid_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      rtype_ff <= rtype_in;
      rstat_ff <= rstat_in;
      htype_ff <= htype_in;
      hstat_ff <= hstat_in;
   end

   mtrr_chain #(
      .ADDRESS_BITS(AW),
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_chain (
      .clock  (clock),
      .reset  (reset),
      .wr     (wr),
      .wr_idx (count_ff[IW-1:0]),
      .wr_base(pbase_ff),
      .wr_end (pend_ff),
      .count  (count_ff),
      .tok_in (tok_in),
      .addr_in(addr),
      .lend_in({2'b0, addr} + {1'b0, len}),
      .tok_out(tok_out)
   );

endmodule

// ----- hw/rtl/mtrr_checker.sv -----
// Port-level checks on the resolver response channel, bound to the top level.
// Depends on mtrr_pkg and the top level's ports.
module mtrr_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);
   import mtrr_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[4:3] <= ST_FULL)
      else $error("undefined status code");

   a_span_type: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[4:3] != ST_OK |-> rsp_tdata[2:0] == MT_UC)
      else $error("error status with nonzero memory type");

endmodule

bind mtrr_memory_type_resolver_unit mtrr_checker u_mtrr_checker (.*);
